FILE: hdl/tarca_pkg.sv
// shared types and constants of the three-axis read-and-clear averager
// used by tarca_div and three_axis_read_clear_averager; depends on nothing

package tarca_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 16;
   localparam int FRAC_W   = 8;
   localparam int SUM_W    = 32;
   localparam int AVG_W    = 24;
   localparam int AXES     = 3;
   localparam int AXIS_W   = 2;

   // divider sizes: dividend is the sum magnitude scaled by the fraction bits
   localparam int DVD_W = SUM_W + FRAC_W;
   localparam int QUO_W = DVD_W - COUNT_W;
   localparam int STEP_W = $clog2(QUO_W + 1);

   // beat widths
   localparam int REQ_DATA_W = 3 * SAMPLE_W;
   localparam int RSP_DATA_W = ((3 * AVG_W + COUNT_W + 1 + 7) / 8) * 8;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DVD_W-1:0]     dividend;
      logic [COUNT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [QUO_W-1:0]     quotient;
   } div_rsp_type;

endpackage

FILE: hdl/three_axis_read_clear_averager.sv
// top level of the three-axis read-and-clear averager
// depends on tarca_pkg and instantiates the shared divider tarca_div

// A sample beat (req_tuser low) adds x, y and z to three 32-bit running sums and
// bumps a 16-bit count; once the count is full further samples are dropped and
// flagged. A read beat (req_tuser high) returns each mean as sum * 256 / count
// with 8 fraction bits, truncated toward zero (zero when no samples were taken),
// with the count and the overflow flag, then clears all. During a read the three
// means go one after another through one restoring divider that yields one
// quotient bit per cycle over 24 steps, each after a load state. The request side
// is not ready during a read. The result sits in an output register, so the next
// beat is taken while it waits; a second read then waits before its final hand-off.

module three_axis_read_clear_averager (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_x, sample_y, sample_z
   input  logic [tarca_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // avg_x, avg_y, avg_z, samples_averaged, overflow_seen, zero padding
   output logic [tarca_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tarca_pkg::*;

   state_type           state_ff, state_in;
   logic [AXIS_W-1:0]   axis_ff, axis_in;
   logic [SUM_W-1:0]    sum_ff [AXES];
   logic [COUNT_W-1:0]  count_ff;
   logic                ovf_ff;
   logic [AVG_W-1:0]    avg_ff [AXES];
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic                req_take;
   logic                take_sample;
   logic                take_read;
   logic                last_axis;
   logic                rsp_free;
   logic                out_load;
   logic                avg_store;
   logic                div_start;
   logic [SUM_W-1:0]    cur_sum;
   logic                cur_neg;
   logic [SUM_W-1:0]    cur_mag;
   logic [AVG_W-1:0]    cur_mean;
   logic [AVG_W-1:0]    final_avg [AXES];

   assign req_take    = req_tvalid & req_tready;
   assign take_sample = req_take & (req_tuser == KIND_SAMPLE);
   assign take_read   = req_take & (req_tuser == KIND_READ);
   assign last_axis   = (axis_ff == AXIS_W'(AXES - 1));
   assign rsp_free    = ~rsp_valid_ff | rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (take_read) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               if (!last_axis)    state_in = ST_LOAD;
               else if (rsp_free) state_in = ST_IDLE;
               else               state_in = ST_HOLD;
            end
         end
         ST_HOLD:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      avg_store  = 1'b0;
      out_load   = 1'b0;
      axis_in    = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            axis_in    = '0;
         end
         ST_LOAD:   div_start = 1'b1;
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               avg_store = 1'b1;
               if (!last_axis) axis_in = axis_ff + 1'b1;
               else            out_load = rsp_free;
            end
         end
         ST_HOLD:   out_load = rsp_free;
         default:   req_tready = 1'b0;
      endcase
   end

   // operand selection for the axis in work
   assign cur_sum = sum_ff[axis_ff];
   assign cur_neg = cur_sum[SUM_W-1];
   assign cur_mag = cur_neg ? (~cur_sum + 1'b1) : cur_sum;
   assign div_req = {div_start, cur_mag, {FRAC_W{1'b0}}, count_ff};

   // sign restore and empty-count case
   always_comb begin
      if (count_ff == '0)
         cur_mean = '0;
      else if (cur_neg)
         cur_mean = ~div_rsp.quotient[AVG_W-1:0] + 1'b1;
      else
         cur_mean = div_rsp.quotient[AVG_W-1:0];
   end

   // the last axis comes straight from the divider when the slot is free
   always_comb begin
      for (int a = 0; a < AXES; a++) final_avg[a] = avg_ff[a];
      if (state_ff == ST_DIVIDE) final_avg[AXES-1] = cur_mean;
   end

   tarca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         if (out_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // running sums, count and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) sum_ff[a] <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (out_load) begin
         for (int a = 0; a < AXES; a++) sum_ff[a] <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (take_sample) begin
         if (count_ff == '1) begin
            ovf_ff <= 1'b1;
         end else begin
            for (int a = 0; a < AXES; a++) begin
               sum_ff[a] <= sum_ff[a]
                  + SUM_W'(signed'(req_tdata[a*SAMPLE_W +: SAMPLE_W]));
            end
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // per-axis means as they come out of the divider
   always_ff @(posedge clock) begin
      if (avg_store) avg_ff[axis_ff] <= cur_mean;
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= RSP_DATA_W'({ovf_ff, count_ff,
                                     final_avg[2], final_avg[1], final_avg[0]});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/tarca_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on tarca_pkg for widths and the request and response structs

module tarca_div (
   input  logic                   clock,
   input  logic                   reset,
   input  tarca_pkg::div_req_type div_req,
   output tarca_pkg::div_rsp_type div_rsp
);
   import tarca_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]    shf_ff, shf_in;
   logic [COUNT_W-1:0]  dvs_ff, dvs_in;
   logic [COUNT_W+1:0]  diff;
   logic                ge;

   // trial subtract of the divisor from the shifted partial remainder
   assign diff = {1'b0, rem_ff, shf_ff[QUO_W-1]} - {2'b00, dvs_ff};
   assign ge   = ~diff[COUNT_W+1];

   // next values of the iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = div_req.dividend[DVD_W-1 -: COUNT_W];
         shf_in  = div_req.dividend[QUO_W-1:0];
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[COUNT_W-1:0] : {rem_ff[COUNT_W-2:0], shf_ff[QUO_W-1]};
         shf_in  = {shf_ff[QUO_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = shf_ff;

endmodule

FILE: test/tb.sv
// self-checking bench for three_axis_read_clear_averager: random and directed beats
// with a running prediction of the three means; depends on tarca_pkg and the rtl

`timescale 1ns / 100ps

module tb;

   import tarca_pkg::*;

   localparam int COUNT_FULL = (1 << COUNT_W) - 1;
   localparam int N_RANDOM   = 1200;

   typedef struct {
      logic                        kind;
      logic signed [SAMPLE_W-1:0]  x;
      logic signed [SAMPLE_W-1:0]  y;
      logic signed [SAMPLE_W-1:0]  z;
      int                          gap;
      bit                          drain;
   } beat_type;

   typedef struct {
      logic [AVG_W-1:0]    avg_x;
      logic [AVG_W-1:0]    avg_y;
      logic [AVG_W-1:0]    avg_z;
      logic [COUNT_W-1:0]  count;
      logic                dropped;
   } mean_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = KIND_SAMPLE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   beat_type  beat_q[$];
   mean_type  means_q[$];
   int        fault_count = 0;

   // predicted state of the averager
   longint sum_x_p = 0;
   longint sum_y_p = 0;
   longint sum_z_p = 0;
   int     taken_p = 0;
   bit     dropped_p = 0;

   int gap_cnt = 0;
   int stall_cnt = 0;
   int rsp_mode = 0;
   int results_seen = 0;

   three_axis_read_clear_averager i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report_fault(string msg);
      $display("error at %0t: %s", $time, msg);
      fault_count++;
   endtask

   task automatic check_field(string name, longint got, longint want);
      if (got != want) begin
         report_fault($sformatf("%s got %0h, want %0h", name, got, want));
      end
   endtask

   // sum * 2^frac / count, truncated toward zero, zero for an empty count
   function automatic logic [AVG_W-1:0] scaled_mean(longint total, int n);
      longint mag;
      longint q;
      if (n == 0) return '0;
      mag = (total < 0) ? -total : total;
      q = (mag * (longint'(1) << FRAC_W)) / n;
      if (total < 0) q = -q;
      return q[AVG_W-1:0];
   endfunction

   // fold one accepted beat into the predicted state
   task automatic absorb_beat(logic kind, logic signed [SAMPLE_W-1:0] x,
                              logic signed [SAMPLE_W-1:0] y,
                              logic signed [SAMPLE_W-1:0] z);
      mean_type m;
      if (kind == KIND_SAMPLE) begin
         if (taken_p >= COUNT_FULL) begin
            dropped_p = 1;
         end else begin
            sum_x_p += x;
            sum_y_p += y;
            sum_z_p += z;
            taken_p++;
         end
      end else begin
         m.avg_x   = scaled_mean(sum_x_p, taken_p);
         m.avg_y   = scaled_mean(sum_y_p, taken_p);
         m.avg_z   = scaled_mean(sum_z_p, taken_p);
         m.count   = taken_p[COUNT_W-1:0];
         m.dropped = dropped_p;
         means_q.push_back(m);
         sum_x_p = 0;
         sum_y_p = 0;
         sum_z_p = 0;
         taken_p = 0;
         dropped_p = 0;
      end
   endtask

   task automatic add_beat(logic kind, int x, int y, int z, int gap, bit drain);
      beat_type b;
      b.kind  = kind;
      b.x     = x[SAMPLE_W-1:0];
      b.y     = y[SAMPLE_W-1:0];
      b.z     = z[SAMPLE_W-1:0];
      b.gap   = gap;
      b.drain = drain;
      beat_q.push_back(b);
   endtask

   // mostly random values, with the extremes and small values now and then
   function automatic int pick_sample();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return $urandom_range(0, 6) - 3;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int pick_gap(bit calm);
      if (calm) return 0;
      return $urandom_range(0, 17);
   endfunction

   // request driver: one beat per handshake, gaps and drain holds from the queue
   always @(posedge clock) begin
      beat_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_beat(req_tuser, req_tdata[SAMPLE_W-1:0],
                        req_tdata[2*SAMPLE_W-1:SAMPLE_W],
                        req_tdata[3*SAMPLE_W-1:2*SAMPLE_W]);
         end
         if (!req_tvalid || req_tready) begin
            if (beat_q.size() != 0 && gap_cnt >= beat_q[0].gap &&
                (!beat_q[0].drain || means_q.size() == 0)) begin
               head = beat_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {head.z, head.y, head.x};
               req_tuser  <= head.kind;
               gap_cnt = 0;
            end else begin
               req_tvalid <= 1'b0;
               if (beat_q.size() != 0 && gap_cnt < beat_q[0].gap) gap_cnt++;
            end
         end
      end
   end

   // result monitor: random stalls in stretches, checks against the oldest mean
   always @(posedge clock) begin
      mean_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (means_q.size() == 0) begin
               report_fault("result beat with nothing expected");
            end else begin
               want = means_q.pop_front();
               check_field("avg_x", rsp_tdata[AVG_W-1:0], want.avg_x);
               check_field("avg_y", rsp_tdata[2*AVG_W-1:AVG_W], want.avg_y);
               check_field("avg_z", rsp_tdata[3*AVG_W-1:2*AVG_W], want.avg_z);
               check_field("samples_averaged",
                           rsp_tdata[3*AVG_W+COUNT_W-1:3*AVG_W], want.count);
               check_field("overflow_seen", rsp_tdata[3*AVG_W+COUNT_W], want.dropped);
            end
            results_seen++;
            if (results_seen % 16 == 0) rsp_mode = $urandom_range(0, 2);
            stall_cnt = (rsp_mode == 0) ? 0 : $urandom_range(0, 17);
         end
         if (stall_cnt != 0) begin
            rsp_tready <= 1'b0;
            stall_cnt--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int n;
      int run_len;
      bit calm;
      // read with nothing taken
      add_beat(KIND_READ, 0, 0, 0, 0, 0);
      // largest and smallest samples
      add_beat(KIND_SAMPLE, 32767, 32767, 32767, 3, 0);
      add_beat(KIND_READ, -1, -1, -1, 0, 0);
      add_beat(KIND_SAMPLE, -32768, -32768, -32768, 0, 0);
      add_beat(KIND_READ, 32767, 0, -32768, 5, 0);
      // truncation toward zero for both signs
      add_beat(KIND_SAMPLE, -1, 1, 0, 0, 0);
      add_beat(KIND_SAMPLE, -1, 1, 0, 0, 0);
      add_beat(KIND_SAMPLE, 0, 0, 0, 0, 0);
      add_beat(KIND_READ, 0, 0, 0, 0, 0);
      // back-to-back reads, the second one empty
      add_beat(KIND_READ, 0, 0, 0, 0, 0);
      add_beat(KIND_SAMPLE, 32767, -32768, 5, 2, 0);
      add_beat(KIND_SAMPLE, -32768, 32767, -5, 0, 0);
      add_beat(KIND_READ, 0, 0, 0, 0, 0);
      add_beat(KIND_READ, 0, 0, 0, 0, 0);
      // hold until every result is back, then a short run and two reads
      add_beat(KIND_SAMPLE, -32768, 32767, pick_sample(), 0, 1);
      for (int i = 0; i < 4; i++) begin
         add_beat(KIND_SAMPLE, pick_sample(), pick_sample(), pick_sample(), 0, 0);
      end
      add_beat(KIND_READ, 0, 0, 0, 0, 0);
      add_beat(KIND_READ, 0, 0, 0, 4, 0);
      // random runs of samples closed by a read
      n = 0;
      while (n < N_RANDOM) begin
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: run_len = $urandom_range(0, 3);
            9:       run_len = $urandom_range(20, 60);
            default: run_len = $urandom_range(4, 20);
         endcase
         for (int i = 0; i < run_len; i++) begin
            add_beat(KIND_SAMPLE, pick_sample(), pick_sample(), pick_sample(),
                     pick_gap(calm), 0);
         end
         add_beat(KIND_READ, pick_sample(), pick_sample(), pick_sample(),
                  pick_gap(calm), ($urandom_range(0, 9) == 0));
         n += run_len + 1;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (beat_q.size() != 0 || req_tvalid || means_q.size() != 0);
      repeat (100) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      #(2_000_000 * 20);
      $display("tb NOT OK");
      $finish;
   end

endmodule
